@@ src/kli_pkg.sv @@
// Shared constants, payload types and controller/datapath interface types.
`default_nettype none

package kli_pkg;

  // Default sizes of the keyframe table
  localparam int DEF_MAX_KEYS   = 16;
  localparam int DEF_COMPONENTS = 3;

  // Fixed field widths
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;
  localparam int SLOT_W  = 4;
  localparam int COMP_W  = 2;

  // Divider: 33 quotient bits, one per cycle
  localparam int                   QUO_W     = DATA_W + 1;
  localparam int                   DIV_CNT_W = $clog2(QUO_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(QUO_W - 1);

  // Operation codes of an input item
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Saturation limits
  localparam logic signed [DATA_W-1:0] RES_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] RES_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                      op;
    logic [SLOT_W-1:0]         entry_index;
    logic signed [DATA_W-1:0]  position;
    logic signed [DATA_W-1:0]  value_first;
    logic signed [DATA_W-1:0]  value_second;
    logic signed [DATA_W-1:0]  value_third;
    logic [COMP_W-1:0]         component;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  result;
    logic                      saturated;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_PAIR1,
    ST_PAIR2,
    ST_DIFF,
    ST_MUL,
    ST_ADD,
    ST_PREP,
    ST_DIV,
    ST_SUM,
    ST_DONE
  } ctl_state_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_WRITE,
    DP_LOAD_QUERY,
    DP_ZERO,
    DP_MATCH,
    DP_PAIR1,
    DP_PAIR2,
    DP_DIFF,
    DP_Y1,
    DP_MUL,
    DP_ADD,
    DP_CLIP,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_SUM
  } dp_op_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CLEAR,
    IDX_INC,
    IDX_DEC,
    IDX_LAST_PAIR
  } idx_op_t;

  typedef struct packed {
    dp_op_t  dp_op;
    idx_op_t idx_op;
  } kli_cmd_t;

  typedef struct packed {
    logic comp_bad;
    logic count_zero;
    logic count_one;
    logic key_lt;
    logic key_eq;
    logic idx_last;
    logic idx_zero;
    logic keys_equal;
    logic too_big;
    logic div_last;
  } kli_status_t;

endpackage

`default_nettype wire

@@ src/kli_ctrl.sv @@
// Sequencer for table writes, key search and the interpolation steps.
`default_nettype none

module kli_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 op,
  input  kli_pkg::kli_status_t status,
  output kli_pkg::kli_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);
  import kli_pkg::*;

  ctl_state_t state, state_next;
  logic       accept;

  assign busy   = (state != ST_IDLE);
  assign done   = (state == ST_DONE);
  assign accept = start && !busy;

  // Hold the current state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && op == OP_QUERY) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.comp_bad || status.count_zero || status.count_one) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.key_lt) begin
          if (status.idx_last) begin
            state_next = ST_PAIR1;
          end
        end else if (status.key_eq) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_PAIR1;
        end
      end
      ST_PAIR1: state_next = ST_PAIR2;
      ST_PAIR2: state_next = ST_DIFF;
      ST_DIFF: begin
        if (status.keys_equal) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_ADD;
      ST_ADD: state_next = ST_PREP;
      ST_PREP: begin
        if (status.too_big) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_last) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM:  state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd.dp_op  = DP_NONE;
    cmd.idx_op = IDX_HOLD;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (op == OP_QUERY) begin
            cmd.dp_op  = DP_LOAD_QUERY;
            cmd.idx_op = IDX_CLEAR;
          end else begin
            cmd.dp_op = DP_WRITE;
          end
        end
      end
      ST_CHECK: begin
        // Slot 0 is already read: a single entry returns its value
        if (status.comp_bad || status.count_zero) begin
          cmd.dp_op = DP_ZERO;
        end else if (status.count_one) begin
          cmd.dp_op = DP_MATCH;
        end
      end
      ST_SCAN: begin
        if (status.key_lt) begin
          cmd.idx_op = status.idx_last ? IDX_LAST_PAIR : IDX_INC;
        end else if (status.key_eq) begin
          cmd.dp_op = DP_MATCH;
        end else if (!status.idx_zero) begin
          cmd.idx_op = IDX_DEC;
        end
      end
      ST_PAIR1: begin
        cmd.dp_op  = DP_PAIR1;
        cmd.idx_op = IDX_INC;
      end
      ST_PAIR2: cmd.dp_op = DP_PAIR2;
      ST_DIFF:  cmd.dp_op = status.keys_equal ? DP_Y1 : DP_DIFF;
      ST_MUL:   cmd.dp_op = DP_MUL;
      ST_ADD:   cmd.dp_op = DP_ADD;
      ST_PREP:  cmd.dp_op = status.too_big ? DP_CLIP : DP_DIV_INIT;
      ST_DIV:   cmd.dp_op = DP_DIV_STEP;
      ST_SUM:   cmd.dp_op = DP_SUM;
      default: begin
        cmd.dp_op  = DP_NONE;
        cmd.idx_op = IDX_HOLD;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/kli_dp.sv @@
// Keyframe table memories, slope arithmetic and bit-serial divider.
`default_nettype none

module kli_dp #(
  parameter int MAX_KEYS   = kli_pkg::DEF_MAX_KEYS,
  parameter int COMPONENTS = kli_pkg::DEF_COMPONENTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [kli_pkg::COUNT_W-1:0]   cfg_wdata,
  input  kli_pkg::item_t                item,
  input  kli_pkg::kli_cmd_t             cmd,
  output kli_pkg::kli_status_t          status,
  output kli_pkg::result_t              answer
);
  import kli_pkg::*;

  localparam int AW    = $clog2(MAX_KEYS);
  localparam int CW    = $clog2(MAX_KEYS + 1);
  localparam int ROW_W = COMPONENTS * DATA_W;
  localparam int WIDE  = 2 * DATA_W;
  localparam int SUM_W = DATA_W + 3;

  // Table storage: one key and one row of components per slot
  logic [DATA_W-1:0]        key_mem [MAX_KEYS];
  logic [ROW_W-1:0]         row_mem [MAX_KEYS];
  logic signed [DATA_W-1:0] key_rd;
  logic [ROW_W-1:0]         row_rd;

  logic [AW-1:0]            idx, idx_next;
  logic [CW-1:0]            count;
  logic signed [DATA_W-1:0] pos;
  logic [COMP_W-1:0]        comp;
  logic signed [DATA_W-1:0] x1, x2, y1, y2;
  logic signed [DATA_W-1:0] comp_val;
  logic [DATA_W-1:0]        mag_a, mag_b, mag_c;
  logic                     neg;
  logic [WIDE-1:0]          prod, num;
  logic [DATA_W-1:0]        rem;
  logic [QUO_W-1:0]         quo;
  logic [DIV_CNT_W-1:0]     div_cnt;
  logic signed [DATA_W-1:0] res;
  logic                     sat;

  logic [AW-1:0]            slot;
  logic                     slot_ok;
  logic [ROW_W-1:0]         row_wr;
  logic [DATA_W:0]          dy, dx, dk;
  logic [DATA_W:0]          div_trial, div_diff;
  logic                     div_ge;
  logic [SUM_W-1:0]         quo_wide, sum_wide;
  logic                     sum_fits;

  function automatic logic [DATA_W-1:0] mag(input logic [DATA_W:0] v);
    logic [DATA_W:0] n;
    n = -v;
    return v[DATA_W] ? n[DATA_W-1:0] : v[DATA_W-1:0];
  endfunction

  // Clamp the written count to the table size
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cfg_wen) begin
      count <= (int'(cfg_wdata) > MAX_KEYS) ? CW'(MAX_KEYS) : CW'(cfg_wdata);
    end
  end

  // Table write: slots beyond the table are dropped, missing components are zero
  assign slot    = AW'(item.entry_index);
  assign slot_ok = int'(item.entry_index) < MAX_KEYS;

  always_comb begin
    row_wr = '0;
    for (int c = 0; c < COMPONENTS; c++) begin
      case (c)
        0:       row_wr[c*DATA_W +: DATA_W] = item.value_first;
        1:       row_wr[c*DATA_W +: DATA_W] = item.value_second;
        2:       row_wr[c*DATA_W +: DATA_W] = item.value_third;
        default: row_wr[c*DATA_W +: DATA_W] = '0;
      endcase
    end
  end

  // Read address follows the slot pointer
  always_comb begin
    case (cmd.idx_op)
      IDX_HOLD:      idx_next = idx;
      IDX_CLEAR:     idx_next = '0;
      IDX_INC:       idx_next = idx + 1'b1;
      IDX_DEC:       idx_next = idx - 1'b1;
      IDX_LAST_PAIR: idx_next = AW'(count - CW'(2));
      default:       idx_next = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      idx <= idx_next;
    end
  end

  // Single write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.dp_op == DP_WRITE && slot_ok) begin
      key_mem[slot] <= item.position;
      row_mem[slot] <= row_wr;
    end
    key_rd <= key_mem[idx_next];
    row_rd <= row_mem[idx_next];
  end

  // Pick the queried component out of the row
  always_comb begin
    comp_val = '0;
    for (int c = 0; c < COMPONENTS; c++) begin
      if (int'(comp) == c) begin
        comp_val = row_rd[c*DATA_W +: DATA_W];
      end
    end
  end

  // Differences of the bracketing pair, one bit wider than the operands
  assign dy = {y2[DATA_W-1], y2} - {y1[DATA_W-1], y1};
  assign dx = {pos[DATA_W-1], pos} - {x1[DATA_W-1], x1};
  assign dk = {x2[DATA_W-1], x2} - {x1[DATA_W-1], x1};

  // Restoring division step: remainder stays below the divisor
  assign div_trial = {rem, quo[QUO_W-1]};
  assign div_ge    = div_trial >= {1'b0, mag_c};
  assign div_diff  = div_trial - {1'b0, mag_c};

  // Apply the signed quotient to the first value
  assign quo_wide = SUM_W'(quo);
  assign sum_wide = {{(SUM_W-DATA_W){y1[DATA_W-1]}}, y1} + (neg ? -quo_wide : quo_wide);
  assign sum_fits = (sum_wide[SUM_W-1:DATA_W-1] == '0) || (sum_wide[SUM_W-1:DATA_W-1] == '1);

  // Datapath registers
  always_ff @(posedge clk) begin
    case (cmd.dp_op)
      DP_LOAD_QUERY: begin
        pos  <= item.position;
        comp <= item.component;
      end
      DP_ZERO: begin
        res <= '0;
        sat <= 1'b0;
      end
      DP_MATCH: begin
        res <= comp_val;
        sat <= 1'b0;
      end
      DP_PAIR1: begin
        x1 <= key_rd;
        y1 <= comp_val;
      end
      DP_PAIR2: begin
        x2 <= key_rd;
        y2 <= comp_val;
      end
      DP_DIFF: begin
        mag_a <= mag(dy);
        mag_b <= mag(dx);
        mag_c <= mag(dk);
        neg   <= dy[DATA_W] ^ dx[DATA_W] ^ dk[DATA_W];
      end
      DP_Y1: begin
        res <= y1;
        sat <= 1'b0;
      end
      DP_MUL: prod <= WIDE'(mag_a) * WIDE'(mag_b);
      // Add half the divisor for round to nearest, ties away from zero
      DP_ADD: num <= prod + WIDE'(mag_c[DATA_W-1:1]);
      DP_CLIP: begin
        res <= neg ? RES_MIN : RES_MAX;
        sat <= 1'b1;
      end
      DP_DIV_INIT: begin
        rem     <= DATA_W'(num[WIDE-1:QUO_W]);
        quo     <= num[QUO_W-1:0];
        div_cnt <= '0;
      end
      DP_DIV_STEP: begin
        rem     <= div_ge ? div_diff[DATA_W-1:0] : div_trial[DATA_W-1:0];
        quo     <= {quo[QUO_W-2:0], div_ge};
        div_cnt <= div_cnt + 1'b1;
      end
      DP_SUM: begin
        if (sum_fits) begin
          res <= sum_wide[DATA_W-1:0];
          sat <= 1'b0;
        end else begin
          res <= sum_wide[SUM_W-1] ? RES_MIN : RES_MAX;
          sat <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Status towards the controller
  assign status.comp_bad   = int'(comp) >= COMPONENTS;
  assign status.count_zero = (count == '0);
  assign status.count_one  = (count == CW'(1));
  assign status.key_lt     = key_rd < pos;
  assign status.key_eq     = key_rd == pos;
  assign status.idx_last   = (CW'(idx) + CW'(1)) == count;
  assign status.idx_zero   = (idx == '0);
  assign status.keys_equal = (x1 == x2);
  // Quotient of 2^33 or more is clipped without dividing
  assign status.too_big    = {1'b0, num[WIDE-1:QUO_W]} >= mag_c;
  assign status.div_last   = (div_cnt == DIV_LAST);

  assign answer.result    = res;
  assign answer.saturated = sat;

endmodule

`default_nettype wire

@@ src/keyframe_linear_interpolator.sv @@
// Top level of the keyframe linear interpolator: controller, datapath and checks.
//
// Usage:
//   Command channel: an item transfers at a rising edge with start high and
//   busy low. A write item (op 0) loads key and components into one slot in
//   that same edge and leaves busy low, so items may follow back to back.
//   A query item (op 1) raises busy until its single result has gone.
//   Result channel: done is high for exactly one cycle with result and
//   saturated valid; the receiver cannot stall, so take the transfer then.
//   Configuration: cfg_wen writes entry_count (clamped to MAX_KEYS) at the
//   edge; write it only while busy is low.
//   A query goes from the check straight to the result for an empty table, a
//   single entry or a bad component; an exact key match ends the key scan; a
//   full interpolation reads the bracketing pair, multiplies, rounds, runs the
//   33-step bit-serial divider and adds; an overflowing slope is clipped before
//   dividing; equal bracketing keys return the first value. The key scan reads
//   one slot per cycle from the key memory. busy drops the cycle after done, so
//   the next item transfers at the edge after the result at the earliest.
//   Reset clears entry_count and the controller; the table contents are
//   undefined until written.
`default_nettype none

module keyframe_linear_interpolator #(
  parameter int MAX_KEYS   = kli_pkg::DEF_MAX_KEYS,
  parameter int COMPONENTS = kli_pkg::DEF_COMPONENTS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  kli_pkg::item_t               item,
  input  logic                         cfg_wen,
  input  logic [kli_pkg::COUNT_W-1:0]  cfg_wdata,
  output logic                         done,
  output kli_pkg::result_t             answer
);
  import kli_pkg::*;

  kli_cmd_t    cmd;
  kli_status_t status;

  kli_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (item.op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  kli_dp #(
    .MAX_KEYS   (MAX_KEYS),
    .COMPONENTS (COMPONENTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .answer    (answer)
  );

`ifndef ASSERT_OFF
  // A write transfer never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.op == OP_WRITE) |=> !done)
    else $error("write item produced a result");

  // A query transfer holds the command channel
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.op == OP_QUERY) |=> busy)
    else $error("query accepted without raising busy");

  // busy releases only after the result transfer
  a_release_after_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> $past(done))
    else $error("busy dropped without a result");

  // A clipped result sits at one of the range limits
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (done && answer.saturated) |-> (answer.result == RES_MAX || answer.result == RES_MIN))
    else $error("saturated result not at a limit");
`endif

endmodule

`default_nettype wire
